// File: hdl/rphc_pkg.sv
// Shared types, register codes and cosine tables for the red pixel HSI classifier.
// No dependencies; used by the top level and the testbench.
package rphc_pkg;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint COS_ONE_DEG = 64'sd1073578288;
    localparam longint Q20_ONE     = 64'sd1048576;
    localparam int     MAX_THETA   = 180;
    localparam int     TAB_DEPTH   = 256;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_HUE_LOW_MAX    = 3'd0,
        REG_HUE_HIGH_MIN   = 3'd1,
        REG_SAT_THRESHOLD  = 3'd2,
        REG_INT_THRESHOLD  = 3'd3,
        REG_RED_THRESHOLD  = 3'd4,
        REG_GB_THRESHOLD   = 3'd5,
        REG_ACTIVE_ROWS    = 3'd6
    } cfg_reg_t;

    typedef logic signed [21:0] cq_tab_t [TAB_DEPTH];
    typedef logic [40:0]        sq_tab_t [TAB_DEPTH];

    function automatic longint round_q20(input longint c);
        longint r;
        if (c >= 0) begin
            r = (c + 512) / 1024;
        end else begin
            r = -((-c + 512) / 1024);
        end
        return r;
    endfunction

    // Q20 cosine of whole degrees 0..180, built by the Q30 recurrence
    function automatic cq_tab_t build_cos_q20();
        cq_tab_t tab;
        longint  prev;
        longint  cur;
        longint  nxt;
        longint  cq;
        tab  = '{default: '0};
        prev = Q30_ONE;
        cur  = COS_ONE_DEG;
        tab[0] = 22'(Q20_ONE);
        for (int k = 1; k <= MAX_THETA; k++) begin
            if (k > 1) begin
                nxt  = (2 * COS_ONE_DEG * cur) / Q30_ONE - prev;
                prev = cur;
                cur  = nxt;
            end
            if (k == 60) begin
                cq = Q20_ONE / 2;
            end else if (k == 90) begin
                cq = 0;
            end else if (k == 120) begin
                cq = -(Q20_ONE / 2);
            end else if (k == 180) begin
                cq = -Q20_ONE;
            end else begin
                cq = round_q20(cur);
            end
            tab[k] = 22'(cq);
        end
        return tab;
    endfunction

    function automatic sq_tab_t build_cos_sq(input cq_tab_t cq);
        sq_tab_t tab;
        longint  v;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            v      = longint'(cq[k]);
            tab[k] = 41'(v * v);
        end
        return tab;
    endfunction

    localparam cq_tab_t COS_Q20 = build_cos_q20();
    localparam sq_tab_t COS_SQ  = build_cos_sq(COS_Q20);

    // First pipeline stage: raw products and per-pixel flags
    typedef struct packed {
        logic [7:0]  red;
        logic        blue_gt_green;
        logic        active;
        logic        color_ok;
        logic        ins_ok;
        logic        n_neg;
        logic [17:0] nsq;
        logic [9:0]  sum;
        logic [7:0]  min_level;
        logic [17:0] sat_rhs;
        logic [17:0] dpart_a;
        logic [17:0] dpart_b;
    } st1_t;

    // Hue search stage payload
    typedef struct packed {
        logic [7:0]  red;
        logic        blue_gt_green;
        logic        active;
        logic        pre_pass;
        logic        n_neg;
        logic [17:0] nsq;
        logic [15:0] dval;
        logic [7:0]  theta;
    } srch_t;

    // Product half of one search step
    typedef struct packed {
        srch_t       base;
        logic [7:0]  cand;
        logic        cand_ok;
        logic [56:0] prod;
    } prod_t;

endpackage

// File: hdl/red_pixel_hsi_classifier.sv
// Red pixel HSI classifier: hue by pipelined binary search over a cosine table,
// saturation, intensity and color thresholds. Depends on rphc_pkg.
//
//  channel  | direction | handshake          | contents
//  s_       | in        | s_tvalid/s_tready  | red, green, blue, row_index
//  m_       | out       | m_tvalid/m_tready  | write_enable (tuser), mask_value
//  cfg_     | in        | cfg_valid/cfg_ready| register index, write data
//
// One pixel per cycle while the output is not stalled; the path from input to
// output is two front stages, eight search steps of two stages each (table
// square times d, then compare) and the output register.
// aresetn is synchronous, clears all stage valid bits and loads the configuration registers with their defaults.
// A stall on m_tready holds every stage and drops s_tready in the same cycle.
module red_pixel_hsi_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], row_index[35:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // mask_value[7:0]
    output logic [0:0]  m_tuser,   // write_enable[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import rphc_pkg::*;

    localparam int STEPS = 8;

    // Configuration registers
    logic [8:0]  hue_low_max_reg;
    logic [8:0]  hue_high_min_reg;
    logic [7:0]  sat_threshold_reg;
    logic [9:0]  intensity_threshold_reg;
    logic [7:0]  red_threshold_reg;
    logic [7:0]  gb_threshold_reg;
    logic [11:0] active_rows_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_low_max_reg         <= 9'd40;
            hue_high_min_reg        <= 9'd350;
            sat_threshold_reg       <= 8'd33;
            intensity_threshold_reg <= 10'd100;
            red_threshold_reg       <= 8'd200;
            gb_threshold_reg        <= 8'd50;
            active_rows_reg         <= 12'd288;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HUE_LOW_MAX:   hue_low_max_reg         <= cfg_data[8:0];
                REG_HUE_HIGH_MIN:  hue_high_min_reg        <= cfg_data[8:0];
                REG_SAT_THRESHOLD: sat_threshold_reg       <= cfg_data[7:0];
                REG_INT_THRESHOLD: intensity_threshold_reg <= cfg_data[9:0];
                REG_RED_THRESHOLD: red_threshold_reg       <= cfg_data[7:0];
                REG_GB_THRESHOLD:  gb_threshold_reg        <= cfg_data[7:0];
                REG_ACTIVE_ROWS:   active_rows_reg         <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Global advance: the whole pipeline moves unless the output is stalled
    logic m_tvalid_reg;
    logic advance;
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // Stage 1: products and flags from the raw pixel
    logic [7:0]         red_in, green_in, blue_in;
    logic [11:0]        row_in;
    logic signed [8:0]  rg_diff, rb_diff, gb_diff;
    logic signed [9:0]  n_val;
    logic signed [19:0] nsq_full;
    logic signed [17:0] pa_val, pb_val;
    st1_t               st1_next, st1_reg;
    logic               st1_vld_reg;

    always_comb begin
        red_in   = s_tdata[7:0];
        green_in = s_tdata[15:8];
        blue_in  = s_tdata[23:16];
        row_in   = s_tdata[35:24];
        rg_diff  = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
        rb_diff  = $signed({1'b0, red_in}) - $signed({1'b0, blue_in});
        gb_diff  = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
        n_val    = $signed({1'b0, red_in, 1'b0}) - $signed({2'b00, green_in})
                 - $signed({2'b00, blue_in});
        nsq_full = n_val * n_val;
        pa_val   = rg_diff * rg_diff;
        pb_val   = rb_diff * gb_diff;

        st1_next.red           = red_in;
        st1_next.blue_gt_green = blue_in > green_in;
        st1_next.active        = row_in < active_rows_reg;
        st1_next.color_ok      = (red_in > red_threshold_reg) &&
                                 (green_in < gb_threshold_reg) &&
                                 (blue_in < gb_threshold_reg);
        st1_next.sum           = {2'b00, red_in} + {2'b00, green_in} + {2'b00, blue_in};
        st1_next.ins_ok        = st1_next.sum >= intensity_threshold_reg;
        st1_next.n_neg         = n_val[9];
        st1_next.nsq           = nsq_full[17:0];
        st1_next.min_level     = red_in;
        if (green_in < st1_next.min_level) begin
            st1_next.min_level = green_in;
        end
        if (blue_in < st1_next.min_level) begin
            st1_next.min_level = blue_in;
        end
        st1_next.sat_rhs = {10'd0, sat_threshold_reg} * {8'd0, st1_next.sum};
        st1_next.dpart_a = pa_val;
        st1_next.dpart_b = pb_val;
    end

    // Stage 2: d, saturation test, combined pass flags
    logic signed [17:0] d_full;
    logic [9:0]         three_min;
    logic [9:0]         sat_diff;
    logic               sat_ok;
    srch_t              st2_next;

    always_comb begin
        d_full    = $signed(st1_reg.dpart_a) + $signed(st1_reg.dpart_b);
        three_min = {2'b00, st1_reg.min_level} + {1'b0, st1_reg.min_level, 1'b0};
        sat_diff  = st1_reg.sum - three_min;
        sat_ok    = {sat_diff, 8'd0} >= st1_reg.sat_rhs;

        st2_next.red           = st1_reg.red;
        st2_next.blue_gt_green = st1_reg.blue_gt_green;
        st2_next.active        = st1_reg.active;
        // a grey pixel has d = 0 and fails, which also covers a zero sum
        st2_next.pre_pass      = (d_full > 18'sd0) && sat_ok && st1_reg.ins_ok &&
                                 st1_reg.color_ok;
        st2_next.n_neg         = st1_reg.n_neg;
        st2_next.nsq           = st1_reg.nsq;
        st2_next.dval          = d_full[15:0];
        st2_next.theta         = 8'd0;
    end

    // Hue search: srch_reg[0] enters, srch_reg[STEPS] holds the final theta
    srch_t srch_reg     [STEPS+1];
    logic  srch_vld_reg [STEPS+1];
    prod_t prod_reg     [STEPS];
    logic  prod_vld_reg [STEPS];
    prod_t prod_next    [STEPS];
    srch_t srch_next    [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic [7:0] STEP_BIT = 8'(1 << (STEPS - 1 - i));

        logic [56:0]       lhs;
        logic signed [21:0] cq_sel;
        logic              hit;

        // product half: square of the candidate cosine times d
        always_comb begin
            prod_next[i].base    = srch_reg[i];
            prod_next[i].cand    = srch_reg[i].theta | STEP_BIT;
            prod_next[i].cand_ok = prod_next[i].cand <= 8'(MAX_THETA);
            prod_next[i].prod    = 57'(COS_SQ[prod_next[i].cand]) *
                                   57'(srch_reg[i].dval);
        end

        // compare half: keep the candidate when x <= cos(candidate)
        always_comb begin
            lhs    = {1'b0, prod_reg[i].base.nsq, 38'd0};
            cq_sel = COS_Q20[prod_reg[i].cand];
            priority if (!prod_reg[i].cand_ok) begin
                hit = 1'b0;
            end else if (prod_reg[i].base.n_neg && !cq_sel[21]) begin
                hit = 1'b1;
            end else if (!prod_reg[i].base.n_neg && cq_sel[21]) begin
                hit = 1'b0;
            end else if (!prod_reg[i].base.n_neg) begin
                hit = lhs <= prod_reg[i].prod;
            end else begin
                hit = lhs >= prod_reg[i].prod;
            end
            srch_next[i] = prod_reg[i].base;
            if (hit) begin
                srch_next[i].theta = prod_reg[i].cand;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                prod_vld_reg[i]   <= 1'b0;
                srch_vld_reg[i+1] <= 1'b0;
            end else if (advance) begin
                prod_vld_reg[i]   <= srch_vld_reg[i];
                srch_vld_reg[i+1] <= prod_vld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                prod_reg[i]   <= prod_next[i];
                srch_reg[i+1] <= srch_next[i];
            end
        end
    end

    // Output stage: hue from theta, band test, final mask
    logic [8:0] hue;
    logic       band_ok;
    logic [7:0] m_tdata_next, m_tdata_reg;
    logic       m_tuser_next, m_tuser_reg;

    always_comb begin
        hue = srch_reg[STEPS].blue_gt_green ? (9'd360 - {1'b0, srch_reg[STEPS].theta})
                                            : {1'b0, srch_reg[STEPS].theta};
        band_ok = (hue <= hue_low_max_reg) ||
                  ((hue >= hue_high_min_reg) && (hue <= 9'd360));
        m_tuser_next = srch_reg[STEPS].active;
        m_tdata_next = (srch_reg[STEPS].active && srch_reg[STEPS].pre_pass && band_ok)
                     ? srch_reg[STEPS].red : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_vld_reg     <= 1'b0;
            srch_vld_reg[0] <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else if (advance) begin
            st1_vld_reg     <= s_tvalid;
            srch_vld_reg[0] <= st1_vld_reg;
            m_tvalid_reg    <= srch_vld_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            st1_reg     <= st1_next;
            srch_reg[0] <= st2_next;
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// File: hdl/rphc_checker.sv
// Port-level checks for the red pixel HSI classifier, bound to the top level.
// Depends only on the top level's ports.
module rphc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [0:0]  m_tuser
);

    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a reset cycle empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // backpressure on the output stops input acceptance in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    // an unwritten row never carries a mask value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("mask value set on inactive row");

endmodule

bind red_pixel_hsi_classifier rphc_checker u_rphc_checker (.*);

// File: tb/sv/tb_red_pixel_hsi_classifier.sv
// Self-checking testbench for red_pixel_hsi_classifier: directed pixels, then random
// pixel streams under several register settings, checked against a local HSI predictor.
// Depends on rphc_pkg (register codes) and the RTL top level.
`timescale 1ns / 1ps

module tb_red_pixel_hsi_classifier;
    import rphc_pkg::*;

    localparam int           CLK_PERIOD  = 12;
    localparam int           PHASE_ITEMS = 190;
    localparam int           NUM_PHASES  = 8;
    localparam int           PIPE_DEPTH  = 19;
    localparam int           HUE_STEPS   = 180;
    localparam logic [2:0]   REG_UNUSED  = 3'd7;
    localparam longint       Q30_UNIT    = 64'sd1073741824;
    localparam longint       COS_1DEG    = 64'sd1073578288;
    localparam longint       Q20_UNIT    = 64'sd1048576;

    typedef struct packed {
        logic       we;
        logic [7:0] mask;
    } pix_result_t;

    typedef struct {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [11:0] row;
        bit          typed;
        pix_result_t res;
    } pix_vec_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;   // red[7:0], green[15:8], blue[23:16], row_index[35:24]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // mask_value[7:0]
    logic [0:0]  m_tuser;          // write_enable[0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;

    // shadow copy of the classifier registers
    logic [8:0]  hue_low_max_q;
    logic [8:0]  hue_high_min_q;
    logic [7:0]  sat_thresh_q;
    logic [9:0]  int_thresh_q;
    logic [7:0]  red_thresh_q;
    logic [7:0]  gb_thresh_q;
    logic [11:0] active_rows_q;

    longint      cos_q20_lut [0:HUE_STEPS];
    pix_result_t mask_expect_q [$];
    pix_vec_t    directed_q [$];

    int  items_sent    = 0;
    int  results_seen  = 0;
    int  passes_seen   = 0;
    int  inactive_seen = 0;
    int  mismatch_cnt  = 0;
    int  burst_left    = 0;
    bit  gaps_enabled  = 1'b1;
    bit  hold_req      = 1'b0;

    red_pixel_hsi_classifier DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(CLK_PERIOD * 300000);
        $display("** red_pixel_hsi_classifier: FAILED **");
        $finish;
    end

    // n / (2*sqrt(d)) <= cq / 2^20, decided on signs and squares
    function automatic bit cos_bound_ok(input longint n, input longint d, input longint cq);
        longint unsigned lhs;
        longint unsigned rhs;
        if (n < 0 && cq >= 0) return 1'b1;
        if (n >= 0 && cq < 0) return 1'b0;
        lhs = n * n;
        lhs = lhs << 40;
        rhs = longint'(cq * cq);
        rhs = rhs * longint'(4 * d);
        if (n >= 0) return lhs <= rhs;
        return lhs >= rhs;
    endfunction

    function automatic int hue_angle_deg(input int n, input int d);
        int theta;
        bit going;
        theta = 0;
        going = 1'b1;
        for (int k = 1; k <= HUE_STEPS; k++) begin
            if (going) begin
                if (cos_bound_ok(longint'(n), longint'(d), cos_q20_lut[k])) theta = k;
                else going = 1'b0;
            end
        end
        return theta;
    endfunction

    function automatic pix_result_t classify_pixel(input int r, input int g, input int b,
                                                   input int row);
        pix_result_t res;
        int          sum;
        int          mn;
        int          d;
        int          hue;
        bit          band;
        bit          sat_ok;
        bit          ins_ok;
        bit          col_ok;
        res = '0;
        if (row >= int'(active_rows_q)) return res;
        res.we = 1'b1;
        sum = r + g + b;
        mn  = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = (r - g) * (r - g) + (r - b) * (g - b);
        // grey pixels and black have no hue and always fail
        if (d > 0 && sum > 0) begin
            hue = hue_angle_deg(2 * r - g - b, d);
            if (b > g) hue = 360 - hue;
            band   = hue <= int'(hue_low_max_q) ||
                     (hue >= int'(hue_high_min_q) && hue <= 360);
            sat_ok = 256 * (sum - 3 * mn) >= int'(sat_thresh_q) * sum;
            ins_ok = sum >= int'(int_thresh_q);
            col_ok = r > int'(red_thresh_q) && g < int'(gb_thresh_q) && b < int'(gb_thresh_q);
            if (band && sat_ok && ins_ok && col_ok) res.mask = 8'(r);
        end
        return res;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_HUE_LOW_MAX:   hue_low_max_q  = val[8:0];
            REG_HUE_HIGH_MIN:  hue_high_min_q = val[8:0];
            REG_SAT_THRESHOLD: sat_thresh_q   = val[7:0];
            REG_INT_THRESHOLD: int_thresh_q   = val[9:0];
            REG_RED_THRESHOLD: red_thresh_q   = val[7:0];
            REG_GB_THRESHOLD:  gb_thresh_q    = val[7:0];
            REG_ACTIVE_ROWS:   active_rows_q  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic idle_input(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 40'({$urandom(), $urandom()});
        end
    endtask

    task automatic offer_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                               input logic [11:0] row, input pix_result_t exp_res);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, row, b, g, r};
        do @(posedge aclk); while (!s_tready);
        mask_expect_q.push_back(exp_res);
        items_sent++;
        if (gaps_enabled) begin
            if (burst_left == 0) begin
                idle_input($urandom_range(1, 10));
                burst_left = $urandom_range(1, 30);
            end else begin
                burst_left--;
            end
        end
    endtask

    // drop valid, then hold until every expected item is back
    task automatic drain_results();
        idle_input(1);
        while (mask_expect_q.size() != 0) @(posedge aclk);
    endtask

    task automatic add_vec(input int r, input int g, input int b, input int row,
                           input bit typed, input logic we, input logic [7:0] mask);
        pix_vec_t v;
        v.r = 8'(r);
        v.g = 8'(g);
        v.b = 8'(b);
        v.row = 12'(row);
        v.typed = typed;
        v.res.we = we;
        v.res.mask = mask;
        directed_q.push_back(v);
    endtask

    task automatic random_pixel();
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [11:0] row;
        logic [7:0]  edge_vals [4];
        edge_vals = '{8'd0, 8'd1, 8'd254, 8'd255};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                r = 8'($urandom_range(150, 255));
                g = 8'($urandom_range(0, 80));
                b = 8'($urandom_range(0, 80));
            end
            5, 6: begin
                r = 8'($urandom_range(0, 255));
                g = 8'($urandom_range(0, 255));
                b = 8'($urandom_range(0, 255));
            end
            7: begin
                r = 8'($urandom_range(0, 255));
                g = r;
                b = r;
            end
            8: begin
                r = edge_vals[2'($urandom_range(0, 3))];
                g = edge_vals[2'($urandom_range(0, 3))];
                b = edge_vals[2'($urandom_range(0, 3))];
            end
            default: begin
                // sweep hue near the red axis on either side
                r = 8'd255;
                if ($urandom_range(0, 1) == 1) begin
                    g = 8'($urandom_range(0, 255));
                    b = 8'd0;
                end else begin
                    g = 8'd0;
                    b = 8'($urandom_range(0, 255));
                end
            end
        endcase
        if (active_rows_q != 0 && $urandom_range(0, 99) < 85)
            row = 12'($urandom_range(0, active_rows_q - 1));
        else
            row = 12'($urandom_range(0, 4095));
        offer_pixel(r, g, b, row, classify_pixel(int'(r), int'(g), int'(b), int'(row)));
    endtask

    // receiver: segments of different stall patterns, plus one long hold on request
    initial begin
        int seg_left;
        int rx_mode;
        int hold_left;
        int tick;
        seg_left  = 0;
        rx_mode   = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req) begin
                hold_left = 150;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    rx_mode  = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 99) < 70);
                    2:       m_tready <= ($urandom_range(0, 99) < 30);
                    default: m_tready <= (tick % 4 != 3);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        pix_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tdata != 8'd0) passes_seen++;
            if (!m_tuser[0]) inactive_seen++;
            if (mask_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: result with nothing pending: we=%0b mask=%0d",
                             $realtime, m_tuser[0], m_tdata);
            end else begin
                want = mask_expect_q.pop_front();
                if (m_tuser[0] !== want.we) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: write_enable expected %0b, got %0b",
                                 $realtime, want.we, m_tuser[0]);
                end
                if (m_tdata !== want.mask) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: mask_value expected %0d, got %0d",
                                 $realtime, want.mask, m_tdata);
                end
            end
        end
    end

    initial begin
        longint prev;
        longint cur;
        longint nxt;
        pix_vec_t v;

        // Q30 cosine recurrence, rounded to Q20, with exact values at 60/90/120/180
        prev = Q30_UNIT;
        cur  = COS_1DEG;
        cos_q20_lut[0] = Q20_UNIT;
        for (int k = 1; k <= HUE_STEPS; k++) begin
            if (k > 1) begin
                nxt  = (2 * COS_1DEG * cur) / Q30_UNIT - prev;
                prev = cur;
                cur  = nxt;
            end
            if (cur >= 0) cos_q20_lut[k] = (cur + 512) / 1024;
            else          cos_q20_lut[k] = -((-cur + 512) / 1024);
        end
        cos_q20_lut[60]  = Q20_UNIT / 2;
        cos_q20_lut[90]  = 0;
        cos_q20_lut[120] = -(Q20_UNIT / 2);
        cos_q20_lut[180] = -Q20_UNIT;

        hue_low_max_q  = 9'd40;
        hue_high_min_q = 9'd350;
        sat_thresh_q   = 8'd33;
        int_thresh_q   = 10'd100;
        red_thresh_q   = 8'd200;
        gb_thresh_q    = 8'd50;
        active_rows_q  = 12'd288;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed pixels on the reset settings
        add_vec(0,   0,   0,   0,    1, 1'b1, 8'd0);    // black, zero sum
        add_vec(255, 255, 255, 0,    1, 1'b1, 8'd0);    // grey, white
        add_vec(128, 128, 128, 5,    1, 1'b1, 8'd0);    // grey, mid level
        add_vec(255, 0,   0,   0,    1, 1'b1, 8'd255);
        add_vec(255, 0,   0,   4095, 1, 1'b0, 8'd0);    // last row, inactive
        add_vec(255, 0,   0,   288,  1, 1'b0, 8'd0);    // first inactive row
        add_vec(255, 0,   0,   287,  1, 1'b1, 8'd255);  // last active row
        add_vec(201, 0,   0,   10,   1, 1'b1, 8'd201);
        add_vec(200, 0,   0,   10,   1, 1'b1, 8'd0);    // red not above threshold
        add_vec(255, 49,  49,  10,   1, 1'b1, 8'd255);
        add_vec(255, 50,  0,   10,   1, 1'b1, 8'd0);    // green too strong
        add_vec(255, 0,   50,  10,   1, 1'b1, 8'd0);    // blue too strong
        add_vec(0,   255, 0,   20,   1, 1'b1, 8'd0);
        add_vec(0,   0,   255, 20,   1, 1'b1, 8'd0);
        add_vec(255, 255, 0,   30,   1, 1'b1, 8'd0);
        add_vec(0,   255, 255, 30,   1, 1'b1, 8'd0);
        add_vec(1,   0,   0,   30,   1, 1'b1, 8'd0);    // below intensity threshold
        add_vec(255, 40,  0,   40,   0, 1'b0, 8'd0);
        add_vec(255, 0,   40,  40,   0, 1'b0, 8'd0);
        add_vec(255, 0,   20,  50,   0, 1'b0, 8'd0);
        add_vec(128, 64,  32,  60,   0, 1'b0, 8'd0);
        add_vec(255, 0,   255, 70,   0, 1'b0, 8'd0);
        add_vec(230, 30,  10,  100,  0, 1'b0, 8'd0);
        add_vec(255, 254, 255, 200,  0, 1'b0, 8'd0);

        foreach (directed_q[i]) begin
            v = directed_q[i];
            offer_pixel(v.r, v.g, v.b, v.row,
                        v.typed ? v.res : classify_pixel(int'(v.r), int'(v.g), int'(v.b),
                                                         int'(v.row)));
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            case (p)
                0: ;   // stay on reset settings
                1: begin
                    // all-ones data exercises width masking
                    write_reg(REG_HUE_LOW_MAX,   12'hFFF);
                    write_reg(REG_HUE_HIGH_MIN,  12'hFFF);
                    write_reg(REG_SAT_THRESHOLD, 12'hFFF);
                    write_reg(REG_INT_THRESHOLD, 12'hFFF);
                    write_reg(REG_RED_THRESHOLD, 12'hFFF);
                    write_reg(REG_GB_THRESHOLD,  12'hFFF);
                    write_reg(REG_ACTIVE_ROWS,   12'hFFF);
                    write_reg(REG_UNUSED,        12'($urandom()));
                end
                2: begin
                    write_reg(REG_HUE_LOW_MAX,   12'd0);
                    write_reg(REG_HUE_HIGH_MIN,  12'd0);
                    write_reg(REG_SAT_THRESHOLD, 12'd0);
                    write_reg(REG_INT_THRESHOLD, 12'd0);
                    write_reg(REG_RED_THRESHOLD, 12'd0);
                    write_reg(REG_GB_THRESHOLD,  12'd0);
                    write_reg(REG_ACTIVE_ROWS,   12'd0);
                end
                3: begin
                    // widest legal bands: almost every colored pixel passes
                    write_reg(REG_HUE_LOW_MAX,   12'd359);
                    write_reg(REG_HUE_HIGH_MIN,  12'd360);
                    write_reg(REG_SAT_THRESHOLD, 12'd0);
                    write_reg(REG_INT_THRESHOLD, 12'd0);
                    write_reg(REG_RED_THRESHOLD, 12'd0);
                    write_reg(REG_GB_THRESHOLD,  12'd255);
                    write_reg(REG_ACTIVE_ROWS,   12'd4095);
                end
                default: begin
                    write_reg(REG_HUE_LOW_MAX,   12'($urandom_range(0, 359)));
                    write_reg(REG_HUE_HIGH_MIN,  12'($urandom_range(0, 360)));
                    write_reg(REG_SAT_THRESHOLD, 12'($urandom_range(0, 255)));
                    write_reg(REG_INT_THRESHOLD, 12'($urandom_range(0, 765)));
                    write_reg(REG_RED_THRESHOLD, 12'($urandom_range(0, 220)));
                    write_reg(REG_GB_THRESHOLD,  12'($urandom_range(30, 255)));
                    write_reg(REG_ACTIVE_ROWS,   12'($urandom_range(1, 4095)));
                    if (p == 5) write_reg(REG_UNUSED, 12'($urandom()));
                end
            endcase

            if (p == 3) begin
                // long receiver hold while items keep coming back to back
                hold_req     = 1'b1;
                gaps_enabled = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == 80) gaps_enabled = 1'b1;
                if (p == 4 && n == 100) drain_results();
                random_pixel();
            end
        end

        drain_results();
        repeat (PIPE_DEPTH + 5) @(posedge aclk);

        $display("Sent %0d pixels over %0d register settings; %0d results checked,",
                 items_sent, NUM_PHASES, results_seen);
        $display("%0d passing red pixels, %0d outside the active rows, %0d mismatches.",
                 passes_seen, inactive_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && mask_expect_q.size() == 0) begin
            $display("** red_pixel_hsi_classifier: PASSED **");
        end else begin
            $display("** red_pixel_hsi_classifier: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/rphc_pkg.sv
hdl/red_pixel_hsi_classifier.sv
hdl/rphc_checker.sv
tb/sv/tb_red_pixel_hsi_classifier.sv
